[hdl/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// uvs_pkg: shared constants for the uv sphere vertex generator
// pipeline depths, fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_DIVISIONS = 1024;
  localparam int CNT_W         = 11;
  localparam int RAD_W         = 16;

  // long division of (index << 32) by the count, one quotient bit a step
  localparam int DIV_BITS      = 33;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // cordic rotation, two micro-rotations per stage
  localparam int CORDIC_STEPS_REQ = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STEPS     = (CORDIC_STEPS_REQ > ATAN_ENTRIES) ?
                                    ATAN_ENTRIES : CORDIC_STEPS_REQ;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_ITER      = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) /
                                    CORDIC_PER_STAGE;
  // multiply, round, iterations, clamp/quadrant
  localparam int CORDIC_LAT       = CORDIC_ITER + 3;

  // input stage, divider, cordic, four product/rounding stages
  localparam int POST_STAGES = 4;
  localparam int PIPE_LAT    = 1 + DIV_STAGES + CORDIC_LAT + POST_STAGES;
  localparam int TEX_DLY     = CORDIC_LAT + POST_STAGES;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

  // configuration register indexes
  localparam logic [1:0] REG_SECTOR_COUNT = 2'd0;
  localparam logic [1:0] REG_STACK_COUNT  = 2'd1;
  localparam logic [1:0] REG_RADIUS       = 2'd2;

  function automatic logic [31:0] atan_q30(input int unsigned k);
    logic [31:0] v;
    case (k)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[hdl/uvs_div.sv]
// ----------------------------------------------------------------------------
// uvs_div: pipelined long divider
// quotient of (idx << 32) / cnt for idx <= cnt, four quotient bits per stage
// ----------------------------------------------------------------------------
module uvs_div
  import uvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CNT_W-1:0]     idx_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic [DIV_BITS-1:0]  quo_o
);

  logic [CNT_W:0]    rem_q [DIV_STAGES];
  logic [DIV_BITS-1:0] quo_q [DIV_STAGES];
  logic [CNT_W:0]    rem_d [DIV_STAGES];
  logic [DIV_BITS-1:0] quo_d [DIV_STAGES];

  always_comb begin
    logic [CNT_W:0]      r;
    logic [DIV_BITS-1:0] q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        r = {1'b0, idx_i};
        q = '0;
      end else begin
        r = rem_q[s-1];
        q = quo_q[s-1];
      end
      for (int t = 0; t < DIV_PER_STAGE; t++) begin
        if (s * DIV_PER_STAGE + t < DIV_BITS) begin
          if (s * DIV_PER_STAGE + t != 0) begin
            r = {r[CNT_W-1:0], 1'b0};
          end
          if (r >= {1'b0, cnt_i}) begin
            r = r - {1'b0, cnt_i};
            q = {q[DIV_BITS-2:0], 1'b1};
          end else begin
            q = {q[DIV_BITS-2:0], 1'b0};
          end
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

[hdl/uvs_cordic.sv]
// ----------------------------------------------------------------------------
// uvs_cordic: pipelined sine and cosine of a 32-bit phase
// phase to radians, cordic rotation, clamp and quadrant fold, Q30 results
// ----------------------------------------------------------------------------
module uvs_cordic
  import uvs_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic [45:0]        pm_lo_q, pm_hi_q;
  logic signed [32:0] z0_q;
  logic [1:0]         quad_q [CORDIC_ITER+2];
  logic signed [33:0] x_q [CORDIC_ITER];
  logic signed [33:0] y_q [CORDIC_ITER];
  logic signed [32:0] z_q [CORDIC_ITER];
  logic signed [33:0] x_d [CORDIC_ITER];
  logic signed [33:0] y_d [CORDIC_ITER];
  logic signed [32:0] z_d [CORDIC_ITER];
  logic [61:0]        zsum;
  logic signed [33:0] xc, yc;
  logic signed [31:0] cos_d, sin_d, cos_q, sin_q;

  // radians: round(r * half_pi / 2^30), split to keep multipliers narrow
  assign zsum = {pm_hi_q, 15'd0} + {16'd0, pm_lo_q} + 62'd536870912;

  always_comb begin
    logic signed [33:0] x, y, xs, ys;
    logic signed [32:0] z;
    for (int s = 0; s < CORDIC_ITER; s++) begin
      if (s == 0) begin
        x = CORDIC_GAIN;
        y = '0;
        z = z0_q;
      end else begin
        x = x_q[s-1];
        y = y_q[s-1];
        z = z_q[s-1];
      end
      for (int t = 0; t < CORDIC_PER_STAGE; t++) begin
        if (s * CORDIC_PER_STAGE + t < CORDIC_STEPS) begin
          xs = x >>> (s * CORDIC_PER_STAGE + t);
          ys = y >>> (s * CORDIC_PER_STAGE + t);
          if (!z[32]) begin
            x = x - ys;
            y = y + xs;
            z = z - $signed({1'b0, atan_q30(s * CORDIC_PER_STAGE + t)});
          end else begin
            x = x + ys;
            y = y - xs;
            z = z + $signed({1'b0, atan_q30(s * CORDIC_PER_STAGE + t)});
          end
        end
      end
      x_d[s] = x;
      y_d[s] = y;
      z_d[s] = z;
    end
  end

  always_comb begin
    xc = x_q[CORDIC_ITER-1];
    yc = y_q[CORDIC_ITER-1];
    if (xc > Q30_ONE) xc = Q30_ONE;
    if (xc < -Q30_ONE) xc = -Q30_ONE;
    if (yc > Q30_ONE) yc = Q30_ONE;
    if (yc < -Q30_ONE) yc = -Q30_ONE;
    case (quad_q[CORDIC_ITER+1])
      2'd0: begin cos_d = xc[31:0];    sin_d = yc[31:0];    end
      2'd1: begin cos_d = -yc[31:0];   sin_d = xc[31:0];    end
      2'd2: begin cos_d = -xc[31:0];   sin_d = -yc[31:0];   end
      default: begin cos_d = yc[31:0]; sin_d = -xc[31:0];   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_lo_q   <= phase_i[14:0] * HALF_PI_Q30;
      pm_hi_q   <= phase_i[29:15] * HALF_PI_Q30;
      quad_q[0] <= phase_i[31:30];
      z0_q      <= $signed({1'b0, zsum[61:30]});
      for (int s = 1; s < CORDIC_ITER + 2; s++) begin
        quad_q[s] <= quad_q[s-1];
      end
      for (int s = 0; s < CORDIC_ITER; s++) begin
        x_q[s] <= x_d[s];
        y_q[s] <= y_d[s];
        z_q[s] <= z_d[s];
      end
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[hdl/uv_sphere_vertex_generator.sv]
// the pipeline has 1 input stage, 9 divider stages, 11 cordic stages and
//   4 product and rounding stages between input transfer and result valid
// throughput: one grid point per cycle; the whole pipeline advances together
//   and holds while a finished result waits for out_ready_i
// reset: counts return to 32 sectors and 16 stacks, radius to 1.0, pipe empty
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator: uv sphere vertex, normal and texture coordinate
// maps a stack/sector grid point to position, unit normal and uv coordinates
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [RAD_W-1:0]         cfg_data_i,
  // grid point input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CNT_W-1:0]         stack_index_i,
  input  logic [CNT_W-1:0]         sector_index_i,
  // vertex result
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [16:0]       position_x_o,
  output logic signed [16:0]       position_y_o,
  output logic signed [16:0]       position_z_o,
  output logic signed [15:0]       normal_x_o,
  output logic signed [15:0]       normal_y_o,
  output logic signed [15:0]       normal_z_o,
  output logic [16:0]              tex_u_o,
  output logic [16:0]              tex_v_o
);

  // configuration registers
  logic [CNT_W-1:0] sector_count_q, stack_count_q;
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] nc, ns;

  // pipeline control: one enable for every stage
  logic                en;
  logic [PIPE_LAT-1:0] vld_q;

  // input stage
  logic [CNT_W-1:0] i_sat_q, j_sat_q;

  // divider results and derived phases
  logic [DIV_BITS-1:0] quo_i, quo_j;
  logic [31:0]         st_phase, se_phase;
  logic [16:0]         tex_u_d, tex_v_d;
  logic [16:0]         tex_u_q [TEX_DLY];
  logic [16:0]         tex_v_q [TEX_DLY];

  // trig results
  logic signed [31:0] cst, sst, cse, sse;

  // post stages
  logic signed [63:0] mx_q, mz_q;
  logic signed [31:0] ny0_q;
  logic signed [63:0] rx_sum, rz_sum;
  logic signed [33:0] rx, rz;
  logic signed [31:0] nx_d, nz_d;
  logic signed [31:0] n1_q [3];
  logic signed [48:0] prod_q [3];
  logic signed [16:0] nrm_q [3];
  logic signed [32:0] nrm_sum [3];
  logic signed [48:0] pos_sum [3];
  logic signed [16:0] pos_q [3];
  logic signed [15:0] nrm_out_q [3];

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_count_q <= CNT_W'(32);
      stack_count_q  <= CNT_W'(16);
      radius_q       <= RAD_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SECTOR_COUNT: sector_count_q <= cfg_data_i[CNT_W-1:0];
        REG_STACK_COUNT:  stack_count_q  <= cfg_data_i[CNT_W-1:0];
        REG_RADIUS:       radius_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the limit acts as the limit
  always_comb begin
    nc = sector_count_q;
    if (sector_count_q == '0) nc = CNT_W'(1);
    else if (sector_count_q > CNT_W'(MAX_DIVISIONS)) nc = CNT_W'(MAX_DIVISIONS);
    ns = stack_count_q;
    if (stack_count_q == '0) ns = CNT_W'(1);
    else if (stack_count_q > CNT_W'(MAX_DIVISIONS)) ns = CNT_W'(MAX_DIVISIONS);
  end

  // ---------------- handshake ----------------
  // advance unless the output register holds a result not yet taken
  assign en         = !vld_q[PIPE_LAT-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[PIPE_LAT-1];

  // ---------------- input stage: index saturation ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      i_sat_q <= (stack_index_i > ns) ? ns : stack_index_i;
      j_sat_q <= (sector_index_i > nc) ? nc : sector_index_i;
    end
  end

  // ---------------- dividers: index / count as a 2^32 fraction ----------------
  uvs_div u_div_stack (
    .clk_i (clk_i),
    .en_i  (en),
    .idx_i (i_sat_q),
    .cnt_i (ns),
    .quo_o (quo_i)
  );

  uvs_div u_div_sector (
    .clk_i (clk_i),
    .en_i  (en),
    .idx_i (j_sat_q),
    .cnt_i (nc),
    .quo_o (quo_j)
  );

  // stack angle spans half a turn, sector angle a full turn (wraps at j == count)
  assign st_phase = quo_i[32:1];
  assign se_phase = quo_j[31:0];

  // texture: floor(frac * 2^16 + 1/2), the half bit sits right below
  assign tex_u_d = quo_j[32:16] + {16'd0, quo_j[15]};
  assign tex_v_d = quo_i[32:16] + {16'd0, quo_i[15]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      tex_u_q[0] <= tex_u_d;
      tex_v_q[0] <= tex_v_d;
      for (int k = 1; k < TEX_DLY; k++) begin
        tex_u_q[k] <= tex_u_q[k-1];
        tex_v_q[k] <= tex_v_q[k-1];
      end
    end
  end

  // ---------------- sine and cosine ----------------
  uvs_cordic u_cordic_stack (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (st_phase),
    .cos_o   (cst),
    .sin_o   (sst)
  );

  uvs_cordic u_cordic_sector (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (se_phase),
    .cos_o   (cse),
    .sin_o   (sse)
  );

  // ---------------- normal products, round half up, clamp ----------------
  assign rx_sum = mx_q + 64'sd536870912;
  assign rz_sum = mz_q + 64'sd536870912;
  assign rx     = rx_sum[63:30];
  assign rz     = rz_sum[63:30];

  always_comb begin
    nx_d = rx[31:0];
    if (rx > Q30_ONE) nx_d = Q30_ONE[31:0];
    else if (rx < -Q30_ONE) nx_d = -Q30_ONE[31:0];
    nz_d = rz[31:0];
    if (rz > Q30_ONE) nz_d = Q30_ONE[31:0];
    else if (rz < -Q30_ONE) nz_d = -Q30_ONE[31:0];
  end

  // normal to Q2.14 and position to Q8.8, both rounded half up
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm_sum[a] = {n1_q[a][31], n1_q[a]} + 33'sd32768;
      pos_sum[a] = prod_q[a] + 49'sd536870912;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products of the two angles
      mx_q  <= sst * cse;
      mz_q  <= sst * sse;
      ny0_q <= cst;
      // rounded and clamped normal in Q30
      n1_q[0] <= nx_d;
      n1_q[1] <= ny0_q;
      n1_q[2] <= nz_d;
      // scale by radius and narrow the normal
      for (int a = 0; a < 3; a++) begin
        prod_q[a]    <= n1_q[a] * $signed({1'b0, radius_q});
        nrm_q[a]     <= nrm_sum[a][32:16];
        pos_q[a]     <= pos_sum[a][46:30];
        nrm_out_q[a] <= nrm_q[a][15:0];
      end
    end
  end

  assign position_x_o = pos_q[0];
  assign position_y_o = pos_q[1];
  assign position_z_o = pos_q[2];
  assign normal_x_o   = nrm_out_q[0];
  assign normal_y_o   = nrm_out_q[1];
  assign normal_z_o   = nrm_out_q[2];
  assign tex_u_o      = tex_u_q[TEX_DLY-1];
  assign tex_v_o      = tex_v_q[TEX_DLY-1];

  // ---------------- checks ----------------
  // the pipe only stalls on a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("pipeline stalled without a held result");

  // an accepted item is registered into the first valid bit vld_q[0]
  a_vld_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item lost at pipe entry");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'd65536 && tex_v_o <= 17'd65536))
    else $error("texture coordinate above one");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384))
    else $error("normal y out of unit range");

endmodule

[sim/uv_sphere_vertex_generator_test.sv]
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_test: self-checking bench for the vertex generator
// drives stack/sector grid points under random input gaps and output stalls,
// predicts position, normal and uv per point and checks every result in order
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_test
  import uvs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // index three has no register behind it
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int ROT_STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam longint UNIT_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } vertex_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [RAD_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [CNT_W-1:0] stack_index_i, sector_index_i;
  logic out_valid_o, out_ready_i;
  logic signed [16:0] position_x_o, position_y_o, position_z_o;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic [16:0] tex_u_o, tex_v_o;

  uv_sphere_vertex_generator dut (.*);

  // mirror of the configuration registers
  logic [10:0] sectors_reg, stacks_reg;
  logic [15:0] radius_reg;

  vertex_t vertex_q[$];
  int errors;
  int gap_pct;        // chance of an input gap at each burst boundary
  int burst_left;
  int stall_mode;     // 0 never stall, 1 light, 2 heavy
  int hold_req;       // long receiver hold-off, in cycles

  // rotation angles, Q30
  longint atan_tab[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q30) return UNIT_Q30;
    if (v < -UNIT_Q30) return -UNIT_Q30;
    return v;
  endfunction

  function automatic longint round_down(input longint v, input int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic [63:0] usable_count(input logic [10:0] c);
    if (c == 0) return 1;
    if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
    return c;
  endfunction

  // cosine and sine in Q30 of a 32 bit phase (one turn = 2^32)
  task automatic phase_trig(input logic [31:0] ph, output longint c, output longint s);
    logic [63:0] prod;
    longint x, y, z, xs, ys;
    prod = {34'd0, ph[29:0]} * 64'd1686629713;
    z = longint'((prod + (64'd1 << 29)) >> 30);
    x = 652032874;
    y = 0;
    for (int k = 0; k < ROT_STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab[k];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab[k];
      end
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_vertex(input logic [10:0] stack_in, input logic [10:0] sector_in,
                                output vertex_t v);
    logic [63:0] ns, nc, i, j, st_ph, se_ph;
    longint cst, sst, cse, sse, rad;
    longint nrm[3];
    ns = usable_count(stacks_reg);
    nc = usable_count(sectors_reg);
    i = (64'(stack_in) > ns) ? ns : 64'(stack_in);
    j = (64'(sector_in) > nc) ? nc : 64'(sector_in);
    st_ph = (i << 31) / ns;
    se_ph = (j << 32) / nc;
    phase_trig(st_ph[31:0], cst, sst);
    phase_trig(se_ph[31:0], cse, sse);
    nrm[0] = clamp_unit(round_down(sst * cse, 30));
    nrm[1] = cst;
    nrm[2] = clamp_unit(round_down(sst * sse, 30));
    rad = longint'({48'd0, radius_reg});
    v.pos_x = 17'(round_down(nrm[0] * rad, 30));
    v.pos_y = 17'(round_down(nrm[1] * rad, 30));
    v.pos_z = 17'(round_down(nrm[2] * rad, 30));
    v.nrm_x = 16'(round_down(nrm[0], 16));
    v.nrm_y = 16'(round_down(nrm[1], 16));
    v.nrm_z = 16'(round_down(nrm[2], 16));
    v.tex_u = 17'((j * 131072 + nc) / (2 * nc));
    v.tex_v = 17'((i * 131072 + ns) / (2 * ns));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous limit on the whole run
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(negedge clk_i) begin
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 5) != 0);
        default: out_ready_i <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    vertex_t want, got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_vertex(stack_index_i, sector_index_i, want);
      vertex_q = {vertex_q, want};
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{position_x_o, position_y_o, position_z_o, normal_x_o, normal_y_o,
              normal_z_o, tex_u_o, tex_v_o};
      if (vertex_q.size() == 0) begin
        $display("%t unexpected result transfer", $realtime);
        errors++;
      end else begin
        want = vertex_q.pop_front();
        if (got.pos_x !== want.pos_x) begin
          $display("%t position_x expected %0d actual %0d", $realtime, want.pos_x, got.pos_x);
          errors++;
        end
        if (got.pos_y !== want.pos_y) begin
          $display("%t position_y expected %0d actual %0d", $realtime, want.pos_y, got.pos_y);
          errors++;
        end
        if (got.pos_z !== want.pos_z) begin
          $display("%t position_z expected %0d actual %0d", $realtime, want.pos_z, got.pos_z);
          errors++;
        end
        if (got.nrm_x !== want.nrm_x) begin
          $display("%t normal_x expected %0d actual %0d", $realtime, want.nrm_x, got.nrm_x);
          errors++;
        end
        if (got.nrm_y !== want.nrm_y) begin
          $display("%t normal_y expected %0d actual %0d", $realtime, want.nrm_y, got.nrm_y);
          errors++;
        end
        if (got.nrm_z !== want.nrm_z) begin
          $display("%t normal_z expected %0d actual %0d", $realtime, want.nrm_z, got.nrm_z);
          errors++;
        end
        if (got.tex_u !== want.tex_u) begin
          $display("%t tex_u expected %0d actual %0d", $realtime, want.tex_u, got.tex_u);
          errors++;
        end
        if (got.tex_v !== want.tex_v) begin
          $display("%t tex_v expected %0d actual %0d", $realtime, want.tex_v, got.tex_v);
          errors++;
        end
      end
    end
  end

  // one grid point transfer; called and left at a falling edge
  task automatic send_point(input logic [10:0] stack_in, input logic [10:0] sector_in);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    stack_index_i  <= stack_in;
    sector_index_i <= sector_in;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every result is back, then let the pipe settle
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 5) @(negedge clk_i);
  endtask

  // register write while idle; the mirror follows the masking
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SECTOR_COUNT: sectors_reg = data[10:0];
      REG_STACK_COUNT:  stacks_reg  = data[10:0];
      REG_RADIUS:       radius_reg  = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // index mostly on the grid, sometimes exactly the count, sometimes anywhere
  function automatic logic [10:0] pick_index(input logic [10:0] cnt);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 11'($urandom_range(0, 2047));
    if (sel == 1) return 11'(usable_count(cnt));
    return 11'($urandom_range(0, 32'(usable_count(cnt))));
  endfunction

  // poles, equator, seam and the index extremes at reset settings
  task automatic test_directed();
    gap_pct = 0;
    stall_mode = 0;
    send_point(0, 0);
    send_point(16, 32);
    send_point(8, 0);
    send_point(8, 8);
    send_point(8, 16);
    send_point(8, 24);
    send_point(4, 5);
    send_point(12, 31);
    send_point(17, 33);     // both indexes past the count
    send_point(2047, 2047); // all index bits set
    send_point(1024, 1);
    send_point(1, 1024);
    send_point(11'h2AA, 11'h555);
    send_point(11'h555, 11'h2AA);
    drain_pipe();
  endtask

  // zero counts, masked and over-limit counts, radius extremes, unused index
  task automatic test_count_limits();
    write_reg(REG_SECTOR_COUNT, 16'd0);
    write_reg(REG_STACK_COUNT, 16'd0);
    write_reg(REG_RADIUS, 16'hFFFF);
    send_point(0, 0);
    send_point(1, 1);
    send_point(5, 7);
    drain_pipe();
    write_reg(REG_SECTOR_COUNT, 16'h07FF);
    write_reg(REG_STACK_COUNT, 16'h07FF);
    write_reg(REG_RADIUS, 16'd0);
    send_point(1024, 1024);
    send_point(2047, 0);
    send_point(512, 256);
    drain_pipe();
    write_reg(REG_SECTOR_COUNT, 16'hF803);  // upper bits dropped, three sectors
    write_reg(REG_STACK_COUNT, 16'hFC01);   // upper bits dropped, 1025 acts as 1024 stacks
    write_reg(REG_RADIUS, 16'h8000);
    write_reg(REG_NONE, 16'h1234);          // ignored
    send_point(0, 1);
    send_point(1, 2);
    send_point(1, 3);
    drain_pipe();
    write_reg(REG_SECTOR_COUNT, 16'd1024);
    write_reg(REG_STACK_COUNT, 16'd1025);
    send_point(1023, 1023);
    send_point(513, 769);
    drain_pipe();
  endtask

  // long receiver hold-off fills the pipe; then the sender waits for all results
  task automatic test_backpressure();
    write_reg(REG_SECTOR_COUNT, 16'd64);
    write_reg(REG_STACK_COUNT, 16'd32);
    write_reg(REG_RADIUS, 16'd1000);
    gap_pct = 0;
    stall_mode = 0;
    hold_req = 150;
    for (int n = 0; n < 60; n++) send_point(pick_index(stacks_reg), pick_index(sectors_reg));
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk_i);
    stall_mode = 1;
    for (int n = 0; n < 20; n++) send_point(pick_index(stacks_reg), pick_index(sectors_reg));
    drain_pipe();
  endtask

  // random settings, each with a batch of random grid points
  task automatic test_random();
    int batch;
    for (int phase = 0; phase < 14; phase++) begin
      write_reg(REG_SECTOR_COUNT,
                (phase % 5 == 0) ? 16'd1 : 16'($urandom_range(0, 16'hFFFF)));
      write_reg(REG_STACK_COUNT,
                (phase % 5 == 1) ? 16'd1024 : 16'($urandom_range(0, 2047)));
      write_reg(REG_RADIUS,
                (phase % 4 == 2) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF)));
      // small counts keep the grid dense in some phases
      if (phase % 3 == 0) write_reg(REG_SECTOR_COUNT, 16'($urandom_range(1, 12)));
      if (phase % 3 == 1) write_reg(REG_STACK_COUNT, 16'($urandom_range(1, 12)));
      gap_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 80);
      stall_mode = phase % 3;
      batch = $urandom_range(80, 130);
      for (int n = 0; n < batch; n++)
        send_point(pick_index(stacks_reg), pick_index(sectors_reg));
      drain_pipe();
    end
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    hold_req = 0;
    stall_mode = 0;
    gap_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SECTOR_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    stack_index_i = '0;
    sector_index_i = '0;
    sectors_reg = 11'd32;
    stacks_reg = 11'd16;
    radius_reg = 16'd256;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_count_limits();
    test_backpressure();
    test_random();

    if (errors == 0 && vertex_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
